// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the polynomial derivative evaluator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed (same-cycle implication)");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed (next-cycle implication)");

`endif

// ===== rtl/pde_pkg.sv =====
// ---------------------------------------------------------------------------
// pde_pkg
// Widths, types and helpers shared by the polynomial derivative evaluator.
// ---------------------------------------------------------------------------
package pde_pkg;

    // Fixed field widths
    localparam int DATA_W    = 64;
    localparam int ORDER_W   = 3;
    localparam int PROD_W    = 2 * DATA_W;
    // falling factorial i!/(i-k)! never exceeds 6!/0! = 720 for a live term
    localparam int FACT_W    = 10;
    localparam int REG_COUNT = 7;
    localparam int REG_IDX_W = 3;

    // Parameter defaults
    localparam int NUM_COEFS_DEF = 7;
    localparam int FRAC_BITS_DEF = 40;

    // Saturation limits
    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Word travelling down the Horner chain
    typedef struct packed {
        logic signed [DATA_W-1:0]  point;
        logic        [ORDER_W-1:0] order;
        logic signed [DATA_W-1:0]  sum;
        logic                      ovf;
    } pde_word_t;

    // Load enables of the two multiplier register stages
    typedef struct packed {
        logic pp;
        logic sum;
    } pde_mul_en_t;

    // (i+1)(i+2)...(i+k), evaluated at elaboration only
    function automatic int fall_fact(input int i, input int k);
        int f;
        f = 1;
        for (int m = 1; m <= 2**ORDER_W - 1; m++)
        begin
            if (m <= k)
            begin
                f = f * (i + m);
            end
        end
        return f;
    endfunction

endpackage

// ===== rtl/pde_if.sv =====
// ---------------------------------------------------------------------------
// pde_if
// Valid/ready channels for evaluation requests and results.
// ---------------------------------------------------------------------------

// Request channel: point and derivative order
interface pde_req_if;
    import pde_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  point;
    logic        [ORDER_W-1:0] deriv_order;

    modport source (output valid, point, deriv_order, input ready);
    modport sink   (input valid, point, deriv_order, output ready);
endinterface

// Result channel: saturated value and overflow flag
interface pde_rsp_if;
    import pde_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     overflow;

    modport source (output valid, result, overflow, input ready);
    modport sink   (input valid, result, overflow, output ready);
endinterface

// ===== rtl/pde_mul64.sv =====
// ---------------------------------------------------------------------------
// pde_mul64
// Two-stage signed 64x64 -> 128 multiplier from four 32-bit partial products.
// ---------------------------------------------------------------------------
module pde_mul64 (
    input  logic                               clk,
    input  pde_pkg::pde_mul_en_t               en,
    input  logic signed [pde_pkg::DATA_W-1:0]  a,
    input  logic signed [pde_pkg::DATA_W-1:0]  b,
    output logic signed [pde_pkg::PROD_W-1:0]  p
);
    import pde_pkg::*;

    localparam int HALF = DATA_W / 2;

    logic        [DATA_W-1:0] ll_next, ll_reg;
    logic signed [DATA_W:0]   hl_next, hl_reg;
    logic signed [DATA_W:0]   lh_next, lh_reg;
    logic signed [DATA_W-1:0] hh_next, hh_reg;
    logic signed [PROD_W-1:0] p_next,  p_reg;

    // Partial products: high halves signed, low halves unsigned
    assign ll_next = DATA_W'({{HALF{1'b0}}, a[HALF-1:0]}) * DATA_W'({{HALF{1'b0}}, b[HALF-1:0]});
    assign hl_next = (DATA_W+1)'($signed(a[DATA_W-1:HALF]))
                   * (DATA_W+1)'($signed({1'b0, b[HALF-1:0]}));
    assign lh_next = (DATA_W+1)'($signed({1'b0, a[HALF-1:0]}))
                   * (DATA_W+1)'($signed(b[DATA_W-1:HALF]));
    assign hh_next = DATA_W'($signed(a[DATA_W-1:HALF])) * DATA_W'($signed(b[DATA_W-1:HALF]));

    // Recombine into the full product
    assign p_next = (PROD_W'(hh_reg) << DATA_W)
                  + (PROD_W'(hl_reg) << HALF)
                  + (PROD_W'(lh_reg) << HALF)
                  + PROD_W'(ll_reg);

    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            ll_reg <= ll_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            hh_reg <= hh_next;
        end
        if (en.sum)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/pde_horner_step.sv =====
// ---------------------------------------------------------------------------
// pde_horner_step
// One Horner step, three stages: sum = sat(sat((sum*z) >>> F) + scaled coef).
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pde_horner_step #(
    parameter int NUM_COEFS = pde_pkg::NUM_COEFS_DEF,
    parameter int FRAC_BITS = pde_pkg::FRAC_BITS_DEF,
    parameter int IDX       = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic signed [pde_pkg::DATA_W-1:0] coef [NUM_COEFS],
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pde_pkg::pde_word_t                in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pde_pkg::pde_word_t                out_word
);
    import pde_pkg::*;

    localparam int DEG     = NUM_COEFS - 1;
    localparam int CW      = $clog2(NUM_COEFS);
    localparam int SCALE_W = DATA_W + FACT_W + 1;
    localparam int SEL_W   = ORDER_W + 1;

    // Falling factorial for this coefficient, one entry per order
    logic [FACT_W-1:0] fact_tbl [2**ORDER_W];

    genvar kk;
    generate
        for (kk = 0; kk < 2**ORDER_W; kk++)
        begin : g_fact
            assign fact_tbl[kk] = FACT_W'(fall_fact(IDX, kk));
        end
    endgenerate

    logic                      en_a, en_b, en_c;
    logic [SEL_W-1:0]          coef_sel;
    logic                      coef_use;
    logic signed [DATA_W-1:0]  coef_pick;
    logic signed [SCALE_W-1:0] scale_prod;
    logic                      scale_fits;
    logic signed [DATA_W-1:0]  scaled_next;
    logic                      sovf_next;

    logic                      a_valid_reg, b_valid_reg, c_valid_reg;
    pde_word_t                 a_word_reg, b_word_reg, c_word_reg;
    logic signed [DATA_W-1:0]  a_scaled_reg, b_scaled_reg;
    logic                      a_sovf_reg, b_sovf_reg;

    pde_mul_en_t               mul_en;
    logic signed [PROD_W-1:0]  mul_prod;
    logic signed [PROD_W-1:0]  shifted;
    logic [PROD_W-FRAC_BITS-DATA_W:0] prod_top;
    logic                      mul_fits;
    logic signed [DATA_W-1:0]  mul_sat;
    logic signed [DATA_W:0]    add_wide;
    logic                      add_fits;
    pde_word_t                 c_word_next;

    // Stage enables: a stage loads when empty or when its successor moves
    assign en_c     = ~c_valid_reg | out_ready;
    assign en_b     = ~b_valid_reg | en_c;
    assign en_a     = ~a_valid_reg | en_b;
    assign in_ready = en_a;

    // Coefficient scaling: coef[IDX+k] * (IDX+k)!/IDX!, zero past the degree
    assign coef_sel   = SEL_W'(IDX) + {1'b0, in_word.order};
    assign coef_use   = (coef_sel <= SEL_W'(DEG));
    assign coef_pick  = coef_use ? coef[coef_sel[CW-1:0]] : '0;
    assign scale_prod = SCALE_W'(coef_pick) * SCALE_W'($signed({1'b0, fact_tbl[in_word.order]}));
    assign scale_fits = (&scale_prod[SCALE_W-1:DATA_W-1]) | ~(|scale_prod[SCALE_W-1:DATA_W-1]);

    always_comb
    begin
        if (!coef_use)
        begin
            scaled_next = '0;
        end
        else if (scale_fits)
        begin
            scaled_next = scale_prod[DATA_W-1:0];
        end
        else
        begin
            scaled_next = scale_prod[SCALE_W-1] ? SMIN : SMAX;
        end
        sovf_next = coef_use & ~scale_fits;
    end

    // Product sum * z over two register stages (aligned with A and B)
    assign mul_en.pp  = en_a;
    assign mul_en.sum = en_b;

    pde_mul64 u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (in_word.sum),
        .b   (in_word.point),
        .p   (mul_prod)
    );

    // Shift, saturate, add scaled coefficient, saturate
    assign shifted  = mul_prod >>> FRAC_BITS;
    assign prod_top = mul_prod[PROD_W-1:FRAC_BITS+DATA_W-1];
    assign mul_fits = (&prod_top) | ~(|prod_top);
    assign mul_sat  = mul_fits ? shifted[DATA_W-1:0] : (mul_prod[PROD_W-1] ? SMIN : SMAX);
    assign add_wide = {mul_sat[DATA_W-1], mul_sat} + {b_scaled_reg[DATA_W-1], b_scaled_reg};
    assign add_fits = (add_wide[DATA_W] == add_wide[DATA_W-1]);

    always_comb
    begin
        c_word_next       = b_word_reg;
        c_word_next.sum   = add_fits ? add_wide[DATA_W-1:0] : (add_wide[DATA_W] ? SMIN : SMAX);
        c_word_next.ovf   = b_word_reg.ovf | b_sovf_reg | ~mul_fits | ~add_fits;
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_c)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_word_reg   <= in_word;
            a_scaled_reg <= scaled_next;
            a_sovf_reg   <= sovf_next;
        end
        if (en_b)
        begin
            b_word_reg   <= a_word_reg;
            b_scaled_reg <= a_scaled_reg;
            b_sovf_reg   <= a_sovf_reg;
        end
        if (en_c)
        begin
            c_word_reg   <= c_word_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_word  = c_word_reg;

    // A blocked input means every stage holds a word
    `ASSERT_IMP(full_when_blocked, clk, rst_n, !in_ready, a_valid_reg && b_valid_reg && c_valid_reg)
    // A stalled output freezes the product stage
    `ASSERT_NEXT(prod_held, clk, rst_n, c_valid_reg && !out_ready && b_valid_reg, b_valid_reg && $stable(mul_prod))
    // Overflow is never cleared along the chain
    `ASSERT_NEXT(ovf_sticky, clk, rst_n, en_c && b_valid_reg && b_word_reg.ovf, c_word_reg.ovf)

endmodule

// ===== rtl/polynomial_derivative_evaluator_top.sv =====
// ---------------------------------------------------------------------------
// polynomial_derivative_evaluator_top
// k-th derivative of a configured polynomial at a point, Q24.40, saturating.
// ---------------------------------------------------------------------------
// Takes one request word per clock and returns one result word per request,
// in order. The path is one input register, then one three-stage Horner step
// per degree, each step holding the coefficient scaling, a two-stage 64x64
// multiplier built from four 32x32 partial products, and the saturating
// shift-and-add. Throughput is one word per cycle; stalls on the result side
// back up stage by stage, so bubbles are squeezed out before the request side
// sees ready drop. Coefficients are written through cfg_wr_en/cfg_index/
// cfg_data; the user must write them only while no request is in flight, as
// the block itself does not enforce this. Writes to indexes at or above
// NUM_COEFS are ignored. Orders above the degree return zero without overflow.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module polynomial_derivative_evaluator_top #(
    parameter int NUM_COEFS = pde_pkg::NUM_COEFS_DEF,
    parameter int FRAC_BITS = pde_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [pde_pkg::REG_IDX_W-1:0]        cfg_index,
    input  logic [pde_pkg::DATA_W-1:0]           cfg_data,
    pde_req_if.sink                              req,
    pde_rsp_if.source                            rsp
);
    import pde_pkg::*;

    localparam int DEG = NUM_COEFS - 1;
    localparam int CW  = $clog2(NUM_COEFS);

    logic signed [DATA_W-1:0] coef_reg [NUM_COEFS];

    logic      s0_valid_reg;
    pde_word_t s0_word_reg;
    pde_word_t s0_word_next;
    logic      en_s0;

    logic      link_valid [NUM_COEFS];
    logic      link_ready [NUM_COEFS];
    pde_word_t link_word  [NUM_COEFS];

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEFS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en && (cfg_index < REG_IDX_W'(NUM_COEFS)))
        begin
            coef_reg[cfg_index[CW-1:0]] <= cfg_data;
        end
    end

    // Input register: Horner start value is the leading coefficient for k = 0
    assign en_s0     = ~s0_valid_reg | link_ready[0];
    assign req.ready = en_s0;

    always_comb
    begin
        s0_word_next.point = req.point;
        s0_word_next.order = req.deriv_order;
        s0_word_next.sum   = (req.deriv_order == '0) ? coef_reg[DEG] : '0;
        s0_word_next.ovf   = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en_s0)
        begin
            s0_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_s0)
        begin
            s0_word_reg <= s0_word_next;
        end
    end

    assign link_valid[0] = s0_valid_reg;
    assign link_word[0]  = s0_word_reg;

    // Horner chain, leading coefficient first
    genvar s;
    generate
        for (s = 0; s < DEG; s++)
        begin : g_step
            pde_horner_step #(
                .NUM_COEFS (NUM_COEFS),
                .FRAC_BITS (FRAC_BITS),
                .IDX       (DEG - 1 - s)
            ) u_step (
                .clk       (clk),
                .rst_n     (rst_n),
                .coef      (coef_reg),
                .in_valid  (link_valid[s]),
                .in_ready  (link_ready[s]),
                .in_word   (link_word[s]),
                .out_valid (link_valid[s+1]),
                .out_ready (link_ready[s+1]),
                .out_word  (link_word[s+1])
            );
        end
    endgenerate

    // Result channel straight from the last step's register
    assign link_ready[DEG] = rsp.ready;
    assign rsp.valid       = link_valid[DEG];
    assign rsp.result      = link_word[DEG].sum;
    assign rsp.overflow    = link_word[DEG].ovf;

    // Orders past the degree come out as a clean zero
    `ASSERT_IMP(zero_past_degree, clk, rst_n, rsp.valid && (link_word[DEG].order > ORDER_W'(DEG)), (rsp.result == '0) && !rsp.overflow)

endmodule
